### design/matrix3_inverse_core_assert.svh
// Assertion macros shared by the matrix inverse core.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef MATRIX3_INVERSE_CORE_ASSERT_SVH
`define MATRIX3_INVERSE_CORE_ASSERT_SVH

// Same-cycle implication.
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/m3i_pkg.sv
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int unsigned DIM     = 3;
  localparam int unsigned NUM_ENT = DIM * DIM;

  // Status of the determinant, carried along the divider lanes.
  typedef struct packed {
    logic neg;
    logic zero;
  } det_flags_t;

endpackage

### design/m3i_cof.sv
`timescale 1ns / 1ps
// Two stages: the eighteen minor products, then the nine signed cofactors.
module m3i_cof import m3i_pkg::*; #(
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ELEM_BITS-1:0] a_i   [NUM_ENT],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [2*ELEM_BITS:0] cof_o [NUM_ENT],
  output logic signed [ELEM_BITS-1:0] col0_o [DIM]
);

  localparam int unsigned E  = ELEM_BITS;
  localparam int unsigned NS = 2;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  logic signed [2*E-1:0] pa_d   [NUM_ENT];
  logic signed [2*E-1:0] pb_d   [NUM_ENT];
  logic signed [2*E-1:0] pa_q   [NUM_ENT];
  logic signed [2*E-1:0] pb_q   [NUM_ENT];
  logic signed [E-1:0]   col_s0_q [DIM];
  logic signed [2*E:0]   cof_q  [NUM_ENT];
  logic signed [E-1:0]   col_s1_q [DIM];

  always_comb begin
    logic nxt;
    nxt = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || nxt;
      nxt    = adv[s];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
    end
  end

  // Cyclic cofactor: C(i,j) = a[i+1][j+1]*a[i+2][j+2] - a[i+1][j+2]*a[i+2][j+1].
  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      localparam int unsigned I1 = (i + 1) % DIM;
      localparam int unsigned I2 = (i + 2) % DIM;
      localparam int unsigned J1 = (j + 1) % DIM;
      localparam int unsigned J2 = (j + 2) % DIM;
      assign pa_d[i*DIM+j] = a_i[I1*DIM+J1] * a_i[I2*DIM+J2];
      assign pb_d[i*DIM+j] = a_i[I1*DIM+J2] * a_i[I2*DIM+J1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        pa_q[e] <= pa_d[e];
        pb_q[e] <= pb_d[e];
      end
      for (int r = 0; r < DIM; r++) col_s0_q[r] <= a_i[r*DIM];
    end
    if (adv[1]) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        cof_q[e] <= {pa_q[e][2*E-1], pa_q[e]} - {pb_q[e][2*E-1], pb_q[e]};
      end
      for (int r = 0; r < DIM; r++) col_s1_q[r] <= col_s0_q[r];
    end
  end

  assign cof_o  = cof_q;
  assign col0_o = col_s1_q;

endmodule

### design/m3i_det.sv
`timescale 1ns / 1ps
// Three stages: split partial products, column terms, determinant and magnitudes.
module m3i_det import m3i_pkg::*; #(
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [2*ELEM_BITS:0] cof_i  [NUM_ENT],
  input  logic signed [ELEM_BITS-1:0] col0_i [DIM],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2*ELEM_BITS-1:0]      cmag_o [NUM_ENT],
  output logic [NUM_ENT-1:0]          cneg_o,
  output logic [3*ELEM_BITS-1:0]      dmag_o,
  output det_flags_t                  dflags_o
);

  localparam int unsigned E  = ELEM_BITS;
  localparam int unsigned TW = 3 * E + 1;
  localparam int unsigned NS = 3;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  logic signed [2*E:0]   hi_q   [DIM];
  logic signed [2*E:0]   lo_q   [DIM];
  logic signed [2*E:0]   cof0_q [NUM_ENT];
  logic signed [TW-1:0]  term_q [DIM];
  logic signed [2*E:0]   cof1_q [NUM_ENT];
  logic signed [TW-1:0]  det_d;
  logic signed [TW-1:0]  dneg_d;
  logic [2*E-1:0]        cmag_q [NUM_ENT];
  logic [NUM_ENT-1:0]    cneg_q;
  logic [3*E-1:0]        dmag_q;
  det_flags_t            dflags_q;

  always_comb begin
    logic nxt;
    nxt = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || nxt;
      nxt    = adv[s];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign det_d  = term_q[0] + term_q[1] + term_q[2];
  assign dneg_d = -det_d;

  always_ff @(posedge clk_i) begin
    // Split each first-column cofactor into a signed high half and unsigned low half.
    if (adv[0]) begin
      for (int r = 0; r < DIM; r++) begin
        hi_q[r] <= col0_i[r] * $signed(cof_i[r*DIM][2*E:E]);
        lo_q[r] <= col0_i[r] * $signed({1'b0, cof_i[r*DIM][E-1:0]});
      end
      cof0_q <= cof_i;
    end
    if (adv[1]) begin
      for (int r = 0; r < DIM; r++) begin
        term_q[r] <= $signed({hi_q[r][TW-E-1:0], {E{1'b0}}})
                   + $signed({{(TW-2*E-1){lo_q[r][2*E]}}, lo_q[r]});
      end
      cof1_q <= cof0_q;
    end
    if (adv[2]) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        cmag_q[e] <= cof1_q[e][2*E] ? (2*E)'(-cof1_q[e]) : cof1_q[e][2*E-1:0];
        cneg_q[e] <= cof1_q[e][2*E] ^ det_d[TW-1];
      end
      dmag_q        <= det_d[TW-1] ? dneg_d[3*E-1:0] : det_d[3*E-1:0];
      dflags_q.neg  <= det_d[TW-1];
      dflags_q.zero <= (det_d == '0);
    end
  end

  assign cmag_o   = cmag_q;
  assign cneg_o   = cneg_q;
  assign dmag_o   = dmag_q;
  assign dflags_o = dflags_q;

endmodule

### design/m3i_div.sv
`timescale 1ns / 1ps
// Nine-lane restoring divider, one quotient bit per stage, with round and saturate.
module m3i_div import m3i_pkg::*; #(
  parameter int unsigned ELEM_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2*ELEM_BITS-1:0]      cmag_i [NUM_ENT],
  input  logic [NUM_ENT-1:0]          cneg_i,
  input  logic [3*ELEM_BITS-1:0]      dmag_i,
  input  det_flags_t                  dflags_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ELEM_BITS-1:0]        res_o [NUM_ENT],
  output logic [ELEM_BITS-1:0]        det_o,
  output logic                        singular_o
);

  localparam int unsigned E   = ELEM_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned QB  = E - 1;
  localparam int unsigned DW  = 3 * E;
  localparam int unsigned NW  = 2 * E + 2 * F;
  localparam int unsigned HW  = NW - QB;
  localparam int unsigned MW  = (HW > DW) ? HW : DW;
  localparam int unsigned RDW = (DW + 1 > 2 * F + 1) ? DW + 1 : 2 * F + 1;
  localparam int unsigned NS  = QB + 2;
  localparam logic [E-1:0] MAX_POS = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MAX_NEG = {1'b1, {(E-1){1'b0}}};

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  logic [DW-1:0]  r_q    [QB+1][NUM_ENT];
  logic [QB-1:0]  q_q    [QB+1][NUM_ENT];
  logic [QB-1:0]  nlo_q  [QB+1][NUM_ENT];
  logic [NUM_ENT-1:0] ovf_q [QB+1];
  logic [NUM_ENT-1:0] neg_q [QB+1];
  logic [DW-1:0]  dmag_q [QB+1];
  det_flags_t     flg_q  [QB+1];
  logic [E-1:0]   detv_q [QB+1];

  logic [E-1:0]   res_q  [NUM_ENT];
  logic [E-1:0]   det_q;
  logic           sing_q;

  always_comb begin
    logic nxt;
    nxt = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || nxt;
      nxt    = adv[s];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Entry stage: overflow test against D << (E-1), first partial remainder,
  // and the rounded determinant.
  logic [RDW-1:0] drnd;
  logic [E-1:0]   detv_d;

  always_comb begin
    drnd = (RDW'(dmag_i) + (RDW'(1) << (2 * F - 1))) >> (2 * F);
    if (dflags_i.zero) begin
      detv_d = '0;
    end else if (|drnd[RDW-1:E-1]) begin
      detv_d = dflags_i.neg ? MAX_NEG : MAX_POS;
    end else begin
      detv_d = dflags_i.neg ? E'(-drnd[E-1:0]) : drnd[E-1:0];
    end
  end

  for (genvar l = 0; l < NUM_ENT; l++) begin : g_ent
    logic [NW-1:0] num;
    logic [MW-1:0] head;
    logic          ovf;
    assign num  = {cmag_i[l], {(2*F){1'b0}}};
    assign head = MW'(num[NW-1:QB]);
    assign ovf  = head >= MW'(dmag_i);

    always_ff @(posedge clk_i) begin
      if (adv[0]) begin
        r_q[0][l]   <= ovf ? '0 : head[DW-1:0];
        q_q[0][l]   <= '0;
        nlo_q[0][l] <= num[QB-1:0];
        ovf_q[0][l] <= ovf;
        neg_q[0][l] <= cneg_i[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dmag_q[0] <= dmag_i;
      flg_q[0]  <= dflags_i;
      detv_q[0] <= detv_d;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int unsigned K = QB - s;
    for (genvar l = 0; l < NUM_ENT; l++) begin : g_lane
      logic [DW:0] trial;
      logic        ge;
      logic [DW:0] diff;
      assign trial = {r_q[s-1][l], nlo_q[s-1][l][K]};
      assign ge    = trial >= {1'b0, dmag_q[s-1]};
      assign diff  = trial - {1'b0, dmag_q[s-1]};

      always_ff @(posedge clk_i) begin
        if (adv[s]) begin
          r_q[s][l]   <= ge ? diff[DW-1:0] : trial[DW-1:0];
          q_q[s][l]   <= q_q[s-1][l] | (QB'(ge) << K);
          nlo_q[s][l] <= nlo_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        dmag_q[s] <= dmag_q[s-1];
        flg_q[s]  <= flg_q[s-1];
        detv_q[s] <= detv_q[s-1];
      end
    end
  end

  // Round half away from zero, apply sign, clamp; a singular matrix gives zero.
  for (genvar l = 0; l < NUM_ENT; l++) begin : g_fin
    logic          up;
    logic [E-1:0]  qr;
    logic [E-1:0]  val;
    assign up = {r_q[QB][l], 1'b0} >= {1'b0, dmag_q[QB]};
    assign qr = E'(q_q[QB][l]) + E'(up);

    always_comb begin
      if (flg_q[QB].zero) begin
        val = '0;
      end else if (ovf_q[QB][l] || qr[E-1]) begin
        val = neg_q[QB][l] ? MAX_NEG : MAX_POS;
      end else begin
        val = neg_q[QB][l] ? E'(-qr) : qr;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[NS-1]) res_q[l] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      det_q  <= detv_q[QB];
      sing_q <= flg_q[QB].zero;
    end
  end

  assign res_o      = res_q;
  assign det_o      = det_q;
  assign singular_o = sing_q;

endmodule

### design/matrix3_inverse_core.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate, signed fixed point (default Q16.16).
//
// Input stream: one word is a whole matrix, nine entries row-major in
// s_axis_tdata. Output stream: one word per matrix with the nine inverse
// entries row-major and the determinant in m_axis_tdata, and the singular
// flag in m_axis_tuser. Results keep input order, one per input word.
//
// Pipeline from accept to m_axis_tvalid: two cofactor stages, three
// determinant stages, one overflow-test stage, ELEM_BITS - 1 restoring
// divide stages (one quotient bit each) and one round/saturate stage that
// is the output register. Throughput: one matrix per cycle unless the
// output stalls, set by the bit-per-stage divider.
//
// Every stage carries its own valid bit and advances when it is empty or
// the stage after it advances, so bubbles close up while the output waits;
// input stalls only once all stages hold words. Reset clears the valid
// bits; nothing is lost or repeated under backpressure.
module matrix3_inverse_core import m3i_pkg::*; #(
  parameter int unsigned ELEM_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // a00,a01,a02,a10,a11,a12,a20,a21,a22 from bit 0 up, zero padding on top
  input  logic [((NUM_ENT*ELEM_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // b00,b01,b02,b10,b11,b12,b20,b21,b22,determinant from bit 0 up, zero padding
  output logic [(((NUM_ENT+1)*ELEM_BITS+7)/8)*8-1:0] m_axis_tdata,
  // singular
  output logic                                      m_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready
);

`include "matrix3_inverse_core_assert.svh"

  localparam int unsigned E     = ELEM_BITS;
  localparam int unsigned OUT_W = (((NUM_ENT + 1) * E + 7) / 8) * 8;

  logic signed [E-1:0]  a     [NUM_ENT];
  logic signed [2*E:0]  cof   [NUM_ENT];
  logic signed [E-1:0]  col0  [DIM];
  logic                 cof_vld, cof_rdy;
  logic [2*E-1:0]       cmag  [NUM_ENT];
  logic [2*E-1:0]       cmag_t [NUM_ENT];
  logic [NUM_ENT-1:0]   cneg, cneg_t;
  logic [3*E-1:0]       dmag;
  det_flags_t           dflags;
  logic                 det_vld, det_rdy;
  logic [E-1:0]         res   [NUM_ENT];
  logic [E-1:0]         det;
  logic                 singular;

  // Unpack the matrix.
  for (genvar e = 0; e < NUM_ENT; e++) begin : g_unpack
    assign a[e] = s_axis_tdata[e*E +: E];
  end

  m3i_cof #(.ELEM_BITS(E)) u_cof (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .a_i         (a),
    .out_valid_o (cof_vld),
    .out_ready_i (cof_rdy),
    .cof_o       (cof),
    .col0_o      (col0)
  );

  m3i_det #(.ELEM_BITS(E)) u_det (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cof_vld),
    .in_ready_o  (cof_rdy),
    .cof_i       (cof),
    .col0_i      (col0),
    .out_valid_o (det_vld),
    .out_ready_i (det_rdy),
    .cmag_o      (cmag),
    .cneg_o      (cneg),
    .dmag_o      (dmag),
    .dflags_o    (dflags)
  );

  // Transpose: inverse entry (i,j) divides cofactor (j,i).
  for (genvar i = 0; i < DIM; i++) begin : g_tr_row
    for (genvar j = 0; j < DIM; j++) begin : g_tr_col
      assign cmag_t[i*DIM+j] = cmag[j*DIM+i];
      assign cneg_t[i*DIM+j] = cneg[j*DIM+i];
    end
  end

  m3i_div #(.ELEM_BITS(E), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (det_vld),
    .in_ready_o  (det_rdy),
    .cmag_i      (cmag_t),
    .cneg_i      (cneg_t),
    .dmag_i      (dmag),
    .dflags_i    (dflags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .det_o       (det),
    .singular_o  (singular)
  );

  // Pack the result word.
  always_comb begin
    m_axis_tdata = '0;
    for (int e = 0; e < NUM_ENT; e++) m_axis_tdata[e*E +: E] = res[e];
    m_axis_tdata[NUM_ENT*E +: E] = det;
  end

  assign m_axis_tuser = singular;

  // A singular matrix must come out as all zeros.
  `M3I_ASSERT_IMP(a_sing_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == OUT_W'(0), "singular word not zero")
  // Input only stalls when the whole pipe is full behind a blocked output.
  `M3I_ASSERT_IMP(a_full_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with room in pipe")
  // An empty output stage lets every stage advance.
  `M3I_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

endmodule

### test/matrix3_inverse_checker.sv
`timescale 1ns / 1ps
module matrix3_inverse_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [319:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output int unsigned  n_pending_o,
  output int unsigned  n_errors_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [319:0] data;
    logic         singular;
  } inverse_t;

  inverse_t inverse_q[$];
  int unsigned errors;

  assign n_pending_o = inverse_q.size();
  assign n_errors_o  = errors;

  // clamp a magnitude to signed 32 bits and apply the sign
  function automatic logic [31:0] clamp_q16(input logic [127:0] mag, input logic neg);
    if (mag[127:31] != '0) begin
      return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return neg ? 32'(-mag[31:0]) : mag[31:0];
  endfunction

  function automatic inverse_t predict_inverse(input logic [287:0] m);
    wide_t        a [3][3];
    wide_t        cof [3][3];
    wide_t        det, c;
    logic [127:0] dmag, num, quo, rem, t;
    logic         neg;
    inverse_t     res;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a[i][j] = wide_t'($signed(m[(i*3+j)*32 +: 32]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                  - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
      end
    end
    det = a[0][0]*cof[0][0] + a[1][0]*cof[1][0] + a[2][0]*cof[2][0];
    res.data = '0;
    res.singular = (det == 0);
    if (res.singular) return res;
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c   = cof[j][i];
        neg = (c < 0) != (det < 0);
        num = ((c < 0) ? -c : c);
        num = num << 32;
        quo = num / dmag;
        rem = num % dmag;
        // round half away from zero on the magnitude
        if ((rem << 1) >= dmag) quo = quo + 1;
        res.data[(i*3+j)*32 +: 32] = clamp_q16(quo, neg);
      end
    end
    t = (dmag + (128'd1 << 31)) >> 32;
    res.data[9*32 +: 32] = clamp_q16(t, det < 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t    want;
    int unsigned bad;
    bad = 0;
    if (!rst_ni) begin
      errors <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) inverse_q.push_back(predict_inverse(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected word %h user %b", $time, m_axis_tdata, m_axis_tuser);
          bad = bad + 1;
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < 10; k++) begin
            if (want.data[k*32 +: 32] !== m_axis_tdata[k*32 +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, k,
                       want.data[k*32 +: 32], m_axis_tdata[k*32 +: 32]);
              bad = bad + 1;
            end
          end
          if (want.singular !== m_axis_tuser) begin
            $display("%0t: singular expected %b actual %b", $time, want.singular,
                     m_axis_tuser);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7fff_ffff;
  localparam logic [31:0] NMIN = 32'h8000_0000;

  logic         clk_i, rst_ni;
  logic [287:0] s_axis_tdata;
  logic         s_axis_tvalid, s_axis_tready;
  logic [319:0] m_axis_tdata;
  logic         m_axis_tuser, m_axis_tvalid, m_axis_tready;
  int unsigned  n_pending, n_errors, cycles;
  int unsigned  idle_pct, stall_pct;
  logic         s_fire;

  matrix3_inverse_core u_dut (.*);

  matrix3_inverse_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .n_pending_o(n_pending), .n_errors_o(n_errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // record accepts at the edge so the driver sees them race-free
  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix3_inverse_core: mismatch");
      $finish;
    end
  end

  // randomize output backpressure
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  task automatic send_matrix(input logic [287:0] m);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = m;
    s_axis_tvalid = 1'b1;
    do @(negedge clk_i); while (!s_fire);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [287:0] diag(input logic [31:0] x, y, z);
    return {x, 96'd0, y, 96'd0, z};
  endfunction

  // entry in a random class: full range, small, or Q16.16 within +-4.0
  function automatic logic [31:0] rand_entry();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8)) - 4);
      default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [287:0] m;
    for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_entry();
    // make some singular by repeating a row or zeroing a column
    case ($urandom_range(9))
      0: m[191:96] = m[95:0];
      1: m[287:192] = m[191:96];
      2: begin
        m[31:0] = '0; m[127:96] = '0; m[223:192] = '0;
      end
      default: ;
    endcase
    return m;
  endfunction

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: identity, zeros, extremes, tiny and huge determinants
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix('0);
    send_matrix({9{PMAX}});
    send_matrix({9{NMIN}});
    send_matrix({9{32'hffff_ffff}});
    send_matrix(diag(NMIN, NMIN, NMIN));
    send_matrix(diag(PMAX, PMAX, PMAX));
    send_matrix(diag(PMAX, NMIN, PMAX));
    send_matrix(diag(32'd1, 32'd1, 32'd1));
    send_matrix(diag(32'hffff_ffff, ONE, ONE));
    send_matrix(diag(32'd2, ONE, ONE));
    send_matrix(diag(32'h0000_8000, ONE, ONE));
    send_matrix(diag(32'h0002_0000, 32'h0002_0000, 32'h0002_0000));
    send_matrix({PMAX, NMIN, PMAX, NMIN, PMAX, NMIN, PMAX, NMIN, PMAX});
    send_matrix({NMIN, PMAX, 32'd0, PMAX, 32'd0, NMIN, 32'd0, NMIN, PMAX});
    send_matrix({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
    send_matrix({32'd3, 32'd2, 32'd1, 32'd6, 32'd5, 32'd4, 32'd9, 32'd8, 32'd7});
    send_matrix({ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0});
    send_matrix({32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 32'h5555_5555,
                 32'haaaa_aaaa, 32'h8000_0001, 32'h1234_5678, 32'hfedc_ba98,
                 32'h7fff_0000});

    // random phases: no idling, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 65 : (p == 3) ? 34 : 0;
      stall_pct = (p == 2) ? 65 : (p == 3) ? 34 : 0;
      for (int n = 0; n < 125; n++) send_matrix(rand_matrix());
      // hold off the sender until the pipeline drains
      while (n_pending != 0) @(negedge clk_i);
    end

    while (n_pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("matrix3_inverse_core: match");
    end else begin
      $display("matrix3_inverse_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/m3i_pkg.sv
design/m3i_cof.sv
design/m3i_det.sv
design/m3i_div.sv
design/matrix3_inverse_core.sv
test/matrix3_inverse_checker.sv
test/tb_top.sv
